>>> hdl/sdtx_pkg.sv
package sdtx_pkg;

  localparam int MAX_BLOCK_BYTES = 512;
  localparam int LEN_W = 10;

  localparam logic [7:0] PAD_BYTE    = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] CMD_PREFIX  = 8'h40;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(512);

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_START  = 2'd1,
    OP_DATA   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RUN_CMD,
    RUN_SINGLE,
    RUN_CRC
  } run_kind_t;

  // one run of output bytes produced by one accepted word
  typedef struct packed {
    run_kind_t   kind;
    logic [39:0] payload;
    logic        rejected;
  } run_desc_t;

endpackage

>>> hdl/sdtx_ctrl.sv
module sdtx_ctrl
  import sdtx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [5:0]       cmd_index,
  input  logic [31:0]      argument,
  input  logic [7:0]       data_byte,
  output logic             emit,
  output run_desc_t        desc
);

  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_next;
  logic             in_block;
  logic             in_block_next;
  logic [LEN_W-1:0] block_length;
  logic [LEN_W-1:0] eff_len;
  logic             full;
  op_t              op;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign op = op_t'(operation);

  always_comb begin
    eff_len = block_length;
    if (block_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (block_length > LEN_W'(MAX_BLOCK_BYTES)) begin
      eff_len = LEN_W'(MAX_BLOCK_BYTES);
    end
  end

  assign full = (count >= eff_len);

  always_comb begin
    crc_next      = crc;
    count_next    = count;
    in_block_next = in_block;
    emit          = 1'b1;
    desc.kind     = RUN_SINGLE;
    desc.payload  = '0;
    desc.rejected = 1'b0;
    unique case (op)
      OP_CMD: begin
        desc.kind    = RUN_CMD;
        desc.payload = {CMD_PREFIX | {2'b00, cmd_index}, argument};
      end
      OP_START: begin
        crc_next      = '0;
        count_next    = '0;
        in_block_next = 1'b1;
        desc.payload  = {START_TOKEN, 32'h0};
      end
      OP_DATA: begin
        if (!in_block || full) begin
          desc.rejected = 1'b1;
        end else begin
          crc_next     = crc16_byte(crc, data_byte);
          count_next   = count + LEN_W'(1);
          desc.payload = {data_byte, 32'h0};
        end
      end
      OP_FINISH: begin
        if (!in_block) begin
          emit = 1'b0;
        end else if (!full) begin
          crc_next     = crc16_byte(crc, PAD_BYTE);
          count_next   = count + LEN_W'(1);
          desc.payload = {PAD_BYTE, 32'h0};
        end else begin
          in_block_next = 1'b0;
          desc.kind     = RUN_CRC;
          desc.payload  = {crc, 24'h0};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= '0;
      count        <= '0;
      in_block     <= 1'b0;
      block_length <= LEN_RESET;
    end else begin
      if (cfg_we) begin
        block_length <= cfg_wdata;
      end
      if (accept) begin
        crc      <= crc_next;
        count    <= count_next;
        in_block <= in_block_next;
      end
    end
  end

endmodule

>>> hdl/sdtx_seq.sv
module sdtx_seq
  import sdtx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  run_desc_t desc_in,
  output logic      free,
  output logic      result_valid,
  input  logic      result_stall,
  output logic [7:0] tx_byte,
  output logic      last,
  output logic      rejected,
  output logic      crc_sent
);

  logic       vld;
  run_desc_t  desc;
  logic [2:0] pos;
  logic [6:0] c7;
  logic       take;

  function automatic logic [6:0] crc7_byte(input logic [6:0] c_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = c_in;
    for (int k = 7; k >= 0; k--) begin
      fb = b[k] ^ c[6];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ 7'h09;
      end
    end
    return c;
  endfunction

  always_comb begin
    tx_byte = PAD_BYTE;
    last    = 1'b1;
    case (desc.kind)
      RUN_CMD: begin
        last = (pos == 3'd7);
        case (pos)
          3'd1:    tx_byte = desc.payload[39:32];
          3'd2:    tx_byte = desc.payload[31:24];
          3'd3:    tx_byte = desc.payload[23:16];
          3'd4:    tx_byte = desc.payload[15:8];
          3'd5:    tx_byte = desc.payload[7:0];
          3'd6:    tx_byte = {c7, 1'b1};
          default: tx_byte = PAD_BYTE;
        endcase
      end
      RUN_CRC: begin
        last    = (pos == 3'd1);
        tx_byte = pos[0] ? desc.payload[31:24] : desc.payload[39:32];
      end
      default: begin
        tx_byte = desc.payload[39:32];
      end
    endcase
  end

  assign rejected     = (desc.kind == RUN_SINGLE) && desc.rejected;
  assign crc_sent     = (desc.kind == RUN_CRC);
  assign result_valid = vld;
  assign take         = vld && !result_stall;
  assign free         = !vld || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (take && last) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
      pos  <= '0;
      c7   <= '0;
    end else if (take && !last) begin
      pos <= pos + 3'd1;
      // command bytes one to five feed the crc7
      if (pos >= 3'd1 && pos <= 3'd5) begin
        c7 <= crc7_byte(c7, tx_byte);
      end
    end
  end

endmodule

>>> hdl/sd_spi_tx_framer.sv
// the first byte of a word appears in the cycle after the word is taken
// throughput: one word per cycle when result_stall is low, bounded by the output
// byte sequencer: a command is eight bytes, a crc close two, anything else one
// a finish with no block open produces nothing
// rst (synchronous) clears crc, byte count and block state, block_length to 512
module sd_spi_tx_framer
  import sdtx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [1:0]       operation,
  input  logic [5:0]       cmd_index,
  input  logic [31:0]      argument,
  input  logic [7:0]       data_byte,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       tx_byte,
  output logic             last,
  output logic             rejected,
  output logic             crc_sent
);

  logic      accept;
  logic      emit;
  logic      free;
  run_desc_t desc;

  assign item_stall = !free;
  assign accept     = item_valid && free;

  sdtx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .operation (operation),
    .cmd_index (cmd_index),
    .argument  (argument),
    .data_byte (data_byte),
    .emit      (emit),
    .desc      (desc)
  );

  sdtx_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && emit),
    .desc_in      (desc),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .tx_byte      (tx_byte),
    .last         (last),
    .rejected     (rejected),
    .crc_sent     (crc_sent)
  );

endmodule
